FILE: rtl/raie_pkg.sv
// Shared types and constants for the registration accept element parser.
package raie_pkg;

	// Status codes carried in an end-of-message word
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_TRUNC_LEN = 3'd2;
	localparam logic [2:0] ST_ELEM_OVR  = 3'd3;
	localparam logic [2:0] ST_ITEM_OVR  = 3'd4;
	localparam logic [2:0] ST_TOO_MANY  = 3'd5;
	localparam logic [2:0] ST_BAD_LEN   = 3'd6;

	// Element identifiers and ranges
	localparam logic [7:0] IEI_ALLOWED    = 8'h15;
	localparam logic [7:0] IEI_CONFIGURED = 8'h31;
	localparam logic [7:0] IEI_LONG_LO    = 8'h70;
	localparam logic [7:0] IEI_LONG_HI    = 8'h7D;

	// Element kinds
	localparam logic [1:0] EK_SKIP       = 2'd0;
	localparam logic [1:0] EK_ALLOWED    = 2'd1;
	localparam logic [1:0] EK_CONFIGURED = 2'd2;

	// Result word kinds
	localparam logic KIND_SLICE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Depth of the queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic        list_kind;
		logic [2:0]  slice_index;
		logic [7:0]  sst;
		logic [23:0] sd;
		logic [7:0]  home_sst;
		logic [23:0] home_sd;
		logic [2:0]  present_mask;
		logic [2:0]  status;
		logic [3:0]  registration_octet;
		logic [3:0]  allowed_count;
		logic [3:0]  configured_count;
	} out_word_t;

	// What one octet leaves behind: a slice word, a status word, or both
	typedef struct packed {
		logic      has_slice;
		logic      has_status;
		out_word_t slice;
		out_word_t status;
	} q_entry_t;

endpackage

FILE: rtl/raie_front.sv
// Front part: walks the octet stream and builds slice and status words.
module raie_front #(
	parameter int MAX_SLICES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  raie_pkg::in_word_t octet,
	output logic               push,
	output raie_pkg::q_entry_t entry
);

	localparam int CW = $clog2(MAX_SLICES + 1);

	typedef enum logic [3:0] {
		PH_LENOCT, PH_RESOCT, PH_IEI, PH_LEN1, PH_LENH, PH_LENL,
		PH_SKIP, PH_ITEMLEN, PH_ITEMBODY, PH_ERR
	} phase_t;

	function automatic logic [2:0] mask_for_length(input logic [3:0] len);
		case (len)
			4'd2:    return 3'd2;
			4'd4:    return 3'd1;
			4'd5:    return 3'd3;
			4'd8:    return 3'd7;
			default: return 3'd0;
		endcase
	endfunction

	phase_t        phase_q, phase_d;
	logic [15:0]   rem_q, rem_d;
	logic [7:0]    lenh_q, lenh_d;
	logic [1:0]    ekind_q, ekind_d;
	logic [3:0]    ilen_q, ilen_d;
	logic [3:0]    ipos_q, ipos_d;
	logic [7:0]    sst_q, sst_d;
	logic [23:0]   sd_q, sd_d;
	logic [7:0]    hsst_q, hsst_d;
	logic [23:0]   hsd_q, hsd_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [3:0]    atot_q, atot_d;
	logic [3:0]    ctot_q, ctot_d;
	logic [2:0]    err_q, err_d;
	logic [3:0]    roct_q, roct_d;

	logic          slice_emit;
	logic [7:0]    b;
	logic [15:0]   elen;
	logic          start;
	logic          commit;
	logic [2:0]    st;

	assign b = octet.data_byte;

	always_comb begin
		phase_d    = phase_q;
		rem_d      = rem_q;
		lenh_d     = lenh_q;
		ekind_d    = ekind_q;
		ilen_d     = ilen_q;
		ipos_d     = ipos_q;
		sst_d      = sst_q;
		sd_d       = sd_q;
		hsst_d     = hsst_q;
		hsd_d      = hsd_q;
		cnt_d      = cnt_q;
		atot_d     = atot_q;
		ctot_d     = ctot_q;
		err_d      = err_q;
		roct_d     = roct_q;
		slice_emit = 1'b0;
		start      = 1'b0;
		commit     = 1'b0;
		elen       = {8'd0, b};
		st         = raie_pkg::ST_OK;
		entry      = '0;

		case (phase_q)
			PH_LENOCT: phase_d = PH_RESOCT;
			PH_RESOCT: begin
				roct_d  = b[3:0];
				phase_d = PH_IEI;
			end
			PH_IEI: begin
				if (!b[7]) begin
					if (b == raie_pkg::IEI_ALLOWED)
						ekind_d = raie_pkg::EK_ALLOWED;
					else if (b == raie_pkg::IEI_CONFIGURED)
						ekind_d = raie_pkg::EK_CONFIGURED;
					else
						ekind_d = raie_pkg::EK_SKIP;
					if (b >= raie_pkg::IEI_LONG_LO && b <= raie_pkg::IEI_LONG_HI)
						phase_d = PH_LENH;
					else
						phase_d = PH_LEN1;
				end
			end
			PH_LEN1: start = 1'b1;
			PH_LENH: begin
				lenh_d  = b;
				phase_d = PH_LENL;
			end
			PH_LENL: begin
				elen  = {lenh_q, b};
				start = 1'b1;
			end
			PH_SKIP: begin
				rem_d = rem_q - 16'd1;
				if (rem_d == 16'd0)
					phase_d = PH_IEI;
			end
			PH_ITEMLEN: begin
				rem_d = rem_q - 16'd1;
				if ({8'd0, b} > rem_d) begin
					err_d   = raie_pkg::ST_ITEM_OVR;
					phase_d = PH_ERR;
				end else if (cnt_q == CW'(MAX_SLICES)) begin
					err_d   = raie_pkg::ST_TOO_MANY;
					phase_d = PH_ERR;
				end else if (b != 8'd1 && b != 8'd2 && b != 8'd4 && b != 8'd5
						&& b != 8'd8) begin
					err_d   = raie_pkg::ST_BAD_LEN;
					phase_d = PH_ERR;
				end else begin
					ilen_d  = b[3:0];
					ipos_d  = 4'd0;
					sst_d   = 8'd0;
					sd_d    = 24'd0;
					hsst_d  = 8'd0;
					hsd_d   = 24'd0;
					phase_d = PH_ITEMBODY;
				end
			end
			PH_ITEMBODY: begin
				rem_d = rem_q - 16'd1;
				if (ipos_q == 4'd0)
					sst_d = b;
				else if (ilen_q == 4'd2 || ipos_q == 4'd4)
					hsst_d = b;
				else if (ipos_q <= 4'd3)
					sd_d = {sd_q[15:0], b};
				else
					hsd_d = {hsd_q[15:0], b};
				ipos_d = ipos_q + 4'd1;
				if (ipos_d >= ilen_q) begin
					slice_emit = 1'b1;
					entry.slice.kind               = raie_pkg::KIND_SLICE;
					entry.slice.list_kind          = (ekind_q == raie_pkg::EK_CONFIGURED);
					entry.slice.slice_index        = 3'(cnt_q);
					entry.slice.sst                = sst_d;
					entry.slice.sd                 = sd_d;
					entry.slice.home_sst           = hsst_d;
					entry.slice.home_sd            = hsd_d;
					entry.slice.present_mask       = mask_for_length(ilen_q);
					entry.slice.registration_octet = roct_q;
					cnt_d = cnt_q + CW'(1);
					if (rem_d == 16'd0)
						commit = 1'b1;
					else
						phase_d = PH_ITEMLEN;
				end
			end
			default: ;
		endcase

		// open an element; an empty one closes at once
		if (start) begin
			rem_d = elen;
			cnt_d = '0;
			if (elen == 16'd0)
				commit = 1'b1;
			else if (ekind_q == raie_pkg::EK_SKIP)
				phase_d = PH_SKIP;
			else
				phase_d = PH_ITEMLEN;
		end

		// close a list and record its count
		if (commit) begin
			if (ekind_q == raie_pkg::EK_ALLOWED)
				atot_d = 4'(cnt_d);
			else if (ekind_q == raie_pkg::EK_CONFIGURED)
				ctot_d = 4'(cnt_d);
			phase_d = PH_IEI;
		end

		entry.has_slice = slice_emit;

		if (octet.end_of_message) begin
			st = err_d;
			if (st == raie_pkg::ST_OK) begin
				if (phase_d == PH_LENOCT || phase_d == PH_RESOCT)
					st = raie_pkg::ST_SHORT;
				else if (phase_d == PH_LEN1 || phase_d == PH_LENH || phase_d == PH_LENL)
					st = raie_pkg::ST_TRUNC_LEN;
				else if (phase_d == PH_SKIP || phase_d == PH_ITEMLEN
						|| phase_d == PH_ITEMBODY)
					st = raie_pkg::ST_ELEM_OVR;
			end
			entry.has_status                = 1'b1;
			entry.status.kind               = raie_pkg::KIND_STATUS;
			entry.status.status             = st;
			entry.status.registration_octet = roct_d;
			entry.status.allowed_count      = atot_d;
			entry.status.configured_count   = ctot_d;

			// back to the start for the next message
			phase_d = PH_LENOCT;
			rem_d   = '0;
			lenh_d  = '0;
			ekind_d = raie_pkg::EK_SKIP;
			ilen_d  = '0;
			ipos_d  = '0;
			sst_d   = '0;
			sd_d    = '0;
			hsst_d  = '0;
			hsd_d   = '0;
			cnt_d   = '0;
			atot_d  = '0;
			ctot_d  = '0;
			err_d   = raie_pkg::ST_OK;
			roct_d  = '0;
		end
	end

	assign push = accept && (slice_emit || octet.end_of_message);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LENOCT;
			rem_q   <= '0;
			lenh_q  <= '0;
			ekind_q <= raie_pkg::EK_SKIP;
			ilen_q  <= '0;
			ipos_q  <= '0;
			sst_q   <= '0;
			sd_q    <= '0;
			hsst_q  <= '0;
			hsd_q   <= '0;
			cnt_q   <= '0;
			atot_q  <= '0;
			ctot_q  <= '0;
			err_q   <= raie_pkg::ST_OK;
			roct_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			lenh_q  <= lenh_d;
			ekind_q <= ekind_d;
			ilen_q  <= ilen_d;
			ipos_q  <= ipos_d;
			sst_q   <= sst_d;
			sd_q    <= sd_d;
			hsst_q  <= hsst_d;
			hsd_q   <= hsd_d;
			cnt_q   <= cnt_d;
			atot_q  <= atot_d;
			ctot_q  <= ctot_d;
			err_q   <= err_d;
			roct_q  <= roct_d;
		end
	end

endmodule

FILE: rtl/raie_queue.sv
// Short queue of parsed entries between the front and back parts.
module raie_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  raie_pkg::q_entry_t push_entry,
	output logic               full,
	input  logic               pop,
	output raie_pkg::q_entry_t head,
	output logic               empty
);

	localparam int PW = raie_pkg::QPTR_W;

	raie_pkg::q_entry_t          mem_q [raie_pkg::QDEPTH];
	logic [raie_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [raie_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [raie_pkg::QPTR_W:0]   count_q;

	assign full  = (count_q == (raie_pkg::QPTR_W + 1)'(raie_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW + 1)'(1);
		end
	end

endmodule

FILE: rtl/raie_back.sv
// Back part: drains queue entries into the result register, one word a cycle while the result is not stalled.
module raie_back (
	input  logic                clk,
	input  logic                arst_n,
	input  raie_pkg::q_entry_t  head,
	input  logic                empty,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_stall,
	output raie_pkg::out_word_t result
);

	logic                valid_q;
	logic                pend_q;
	raie_pkg::out_word_t out_q;
	raie_pkg::out_word_t stat_q;
	logic                load;

	assign load         = !valid_q || !result_stall;
	assign pop          = load && !pend_q && !empty;
	assign result_valid = valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!empty) begin
				valid_q <= 1'b1;
				pend_q  <= head.has_slice && head.has_status;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q <= stat_q;
			end else if (!empty) begin
				out_q  <= head.has_slice ? head.slice : head.status;
				stat_q <= head.status;
			end
		end
	end

endmodule

FILE: rtl/registration_accept_ie_parser_core.sv
// Registration accept element parser: one octet a cycle, results a word at a time.
// Throughput: one octet per cycle; the front finishes each octet at the edge that accepts it and
// stalls the input only while the 4-entry queue is full.
// An accepted octet's word is written into the queue, then moved into the result register.
// A final octet that ends a slice makes two words, the slice word before the status word.
// Reset: arst_n clears the parser, queue and result valid; the parser also restarts
// after every end-of-message octet.
module registration_accept_ie_parser_core #(
	parameter int MAX_SLICES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                octet_valid,
	output logic                octet_stall,
	input  raie_pkg::in_word_t  octet,
	output logic                result_valid,
	input  logic                result_stall,
	output raie_pkg::out_word_t result
);

	logic               accept;
	logic               push;
	logic               full;
	logic               pop;
	logic               empty;
	raie_pkg::q_entry_t push_entry;
	raie_pkg::q_entry_t head;

	// Hold off the source only when the queue has no room for a new entry.
	assign octet_stall = full;
	assign accept      = octet_valid && !full;

	// Front: classify elements, gather slice items, build the status word.
	raie_front #(
		.MAX_SLICES(MAX_SLICES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.octet  (octet),
		.push   (push),
		.entry  (push_entry)
	);

	// Queue: decouple parsing from the result port.
	raie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	// Back: advance entries into the output register, slice word before status word.
	raie_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: test/registration_accept_ie_parser_core_tb.sv
// Self-checking bench for the registration accept element parser: script, random messages.
module registration_accept_ie_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import raie_pkg::*;

	localparam int SLICE_LIMIT = 8;
	localparam int RANDOM_OCTETS = 1600;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AT_WORD = 60;
	localparam int MAX_REPORTS = 40;

	// Legal S-NSSAI item lengths
	localparam logic [7:0] ITEM_LENGTHS [5] = '{8'd1, 8'd2, 8'd4, 8'd5, 8'd8};

	// Where the parser stands inside the message
	typedef enum logic [3:0] {
		P_LENGTH, P_RESULT, P_IEI, P_LEN_ONE, P_LEN_HI, P_LEN_LO,
		P_SKIP, P_ITEM_LEN, P_ITEM_BODY, P_FAILED
	} parse_phase_t;

	// One scripted octet; typed rows carry the status word spelled out by hand
	typedef struct packed {
		logic [7:0] data;
		logic       eom;
		logic       typed;
		logic [2:0] st;
		logic [3:0] reg_nib;
		logic [3:0] acnt;
		logic [3:0] ccnt;
	} script_row_t;

	localparam script_row_t SCRIPT [33] = '{
		// short message: ends on its very first octet
		'{8'h00, 1'b1, 1'b1, ST_SHORT,    4'h0, 4'h0, 4'h0},
		// result octet all ones, message ends cleanly on an element boundary
		'{8'h01, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hFF, 1'b1, 1'b1, ST_OK,       4'hF, 4'h0, 4'h0},
		// truncated length: ends right on an allowed NSSAI IEI
		'{8'h01, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h09, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h15, 1'b1, 1'b1, ST_TRUNC_LEN, 4'h9, 4'h0, 4'h0},
		// configured list with one all-ones 5-octet item, then an item overrun;
		// the status keeps the configured count that completed before the error
		'{8'h01, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h0A, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h31, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h06, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h05, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h15, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h02, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h05, 1'b1, 1'b1, ST_ITEM_OVR, 4'hA, 4'h0, 4'h1},
		// empty allowed list, then a configured item of length zero
		'{8'h01, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h03, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h15, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h00, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h31, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h01, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h00, 1'b1, 1'b1, ST_BAD_LEN,  4'h3, 4'h0, 4'h0},
		// one-octet element, a two-octet-length element cut short
		'{8'h01, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h05, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h80, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h7D, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h00, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'h02, 1'b0, 1'b0, ST_OK,       4'h0, 4'h0, 4'h0},
		'{8'hAA, 1'b1, 1'b1, ST_ELEM_OVR, 4'h5, 4'h0, 4'h0}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      octet_valid;
	logic      octet_stall;
	in_word_t  octet;
	logic      result_valid;
	logic      result_stall;
	out_word_t result;

	// Parser state mirrored by the bench
	parse_phase_t phase;
	logic [15:0]  owed;
	logic [7:0]   len_hi;
	logic [1:0]   elem_kind;
	logic [7:0]   cur_len;
	logic [3:0]   cur_pos;
	logic [7:0]   cur_sst;
	logic [23:0]  cur_sd;
	logic [7:0]   cur_hsst;
	logic [23:0]  cur_hsd;
	logic [3:0]   list_cnt;
	logic [3:0]   allowed_tot;
	logic [3:0]   config_tot;
	logic [2:0]   err_code;
	logic [3:0]   reg_nib;

	out_word_t  due_words [$];
	logic [7:0] msg [$];
	out_word_t  want;

	int  fail_count = 0;
	int  octets_sent = 0;
	int  words_taken = 0;
	int  slice_words = 0;
	int  status_words = 0;
	int  status_seen [8];
	int  quiet_cycles = 0;
	bit  snd_quiet = 1'b0;
	bit  rcv_quiet = 1'b0;
	bit  long_hold_done = 1'b0;

	registration_accept_ie_parser_core #(.MAX_SLICES(SLICE_LIMIT)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.octet_valid  (octet_valid),
		.octet_stall  (octet_stall),
		.octet        (octet),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	task automatic clear_parser();
		phase = P_LENGTH;
		owed = '0;
		len_hi = '0;
		elem_kind = EK_SKIP;
		cur_len = '0;
		cur_pos = '0;
		cur_sst = '0;
		cur_sd = '0;
		cur_hsst = '0;
		cur_hsd = '0;
		list_cnt = '0;
		allowed_tot = '0;
		config_tot = '0;
		err_code = ST_OK;
		reg_nib = '0;
	endtask

	function automatic out_word_t status_word(logic [2:0] st, logic [3:0] nib,
			logic [3:0] acnt, logic [3:0] ccnt);
		out_word_t w;
		w = '0;
		w.kind = KIND_STATUS;
		w.status = st;
		w.registration_octet = nib;
		w.allowed_count = acnt;
		w.configured_count = ccnt;
		return w;
	endfunction

	// Latch the list count into its total and go look for the next element
	task automatic close_list();
		if (elem_kind == EK_ALLOWED)
			allowed_tot = list_cnt;
		else if (elem_kind == EK_CONFIGURED)
			config_tot = list_cnt;
		phase = P_IEI;
	endtask

	task automatic open_element(logic [15:0] len);
		owed = len;
		list_cnt = '0;
		if (len == 16'd0)
			close_list();
		else
			phase = (elem_kind == EK_SKIP) ? P_SKIP : P_ITEM_LEN;
	endtask

	// First error latches; everything up to the last octet is then ignored
	task automatic fail_with(logic [2:0] code);
		err_code = code;
		phase = P_FAILED;
	endtask

	// Advance the mirrored parser by one octet and queue the words it makes
	task automatic parse_octet(in_word_t w);
		logic [7:0] b;
		logic [2:0] st;
		out_word_t  sw;
		b = w.data_byte;
		case (phase)
			P_LENGTH: phase = P_RESULT;
			P_RESULT: begin
				reg_nib = b[3:0];
				phase = P_IEI;
			end
			P_IEI: if (!b[7]) begin
				elem_kind = (b == IEI_ALLOWED) ? EK_ALLOWED :
					(b == IEI_CONFIGURED) ? EK_CONFIGURED : EK_SKIP;
				phase = (b >= IEI_LONG_LO && b <= IEI_LONG_HI) ? P_LEN_HI : P_LEN_ONE;
			end
			P_LEN_ONE: open_element({8'd0, b});
			P_LEN_HI: begin
				len_hi = b;
				phase = P_LEN_LO;
			end
			P_LEN_LO: open_element({len_hi, b});
			P_SKIP: begin
				owed--;
				if (owed == 16'd0)
					phase = P_IEI;
			end
			P_ITEM_LEN: begin
				owed--;
				// overrun beats count, count beats length
				if ({8'd0, b} > owed)
					fail_with(ST_ITEM_OVR);
				else if (list_cnt == SLICE_LIMIT)
					fail_with(ST_TOO_MANY);
				else if (b != 8'd1 && b != 8'd2 && b != 8'd4 && b != 8'd5 && b != 8'd8)
					fail_with(ST_BAD_LEN);
				else begin
					cur_len = b;
					cur_pos = '0;
					cur_sst = '0;
					cur_sd = '0;
					cur_hsst = '0;
					cur_hsd = '0;
					phase = P_ITEM_BODY;
				end
			end
			P_ITEM_BODY: begin
				owed--;
				if (cur_pos == 4'd0)
					cur_sst = b;
				else if (cur_len == 8'd2 || cur_pos == 4'd4)
					cur_hsst = b;
				else if (cur_pos <= 4'd3)
					cur_sd = {cur_sd[15:0], b};
				else
					cur_hsd = {cur_hsd[15:0], b};
				cur_pos++;
				if ({4'd0, cur_pos} >= cur_len) begin
					sw = '0;
					sw.kind = KIND_SLICE;
					sw.list_kind = (elem_kind == EK_CONFIGURED);
					sw.slice_index = list_cnt[2:0];
					sw.sst = cur_sst;
					sw.sd = cur_sd;
					sw.home_sst = cur_hsst;
					sw.home_sd = cur_hsd;
					// bit 0 sd, bit 1 home sst, bit 2 home sd
					case (cur_len)
						8'd2: sw.present_mask = 3'b010;
						8'd4: sw.present_mask = 3'b001;
						8'd5: sw.present_mask = 3'b011;
						8'd8: sw.present_mask = 3'b111;
						default: sw.present_mask = 3'b000;
					endcase
					sw.registration_octet = reg_nib;
					due_words.push_back(sw);
					list_cnt++;
					if (owed == 16'd0)
						close_list();
					else
						phase = P_ITEM_LEN;
				end
			end
			default: ;
		endcase

		if (w.end_of_message) begin
			st = err_code;
			if (st == ST_OK) begin
				case (phase)
					P_LENGTH, P_RESULT: st = ST_SHORT;
					P_LEN_ONE, P_LEN_HI, P_LEN_LO: st = ST_TRUNC_LEN;
					P_SKIP, P_ITEM_LEN, P_ITEM_BODY: st = ST_ELEM_OVR;
					default: ;
				endcase
			end
			due_words.push_back(status_word(st, reg_nib, allowed_tot, config_tot));
			clear_parser();
		end
	endtask

	// ---------------------------------------------------------------- message builder

	// Mostly well-formed messages with random content; a fifth are pure noise,
	// and some of the rest get cut short or have one octet trashed.
	task automatic build_message();
		int ies;
		int pick;
		int count;
		int len;
		int cut;
		logic [7:0] iei;
		logic [7:0] slice_len;
		logic [7:0] body [$];
		msg.delete();
		if ($urandom_range(0, 4) == 0) begin
			len = $urandom_range(1, 12);
			repeat (len) msg.push_back(8'($urandom));
		end else begin
			msg.push_back(8'($urandom));
			msg.push_back(8'($urandom));
			ies = $urandom_range(0, 4);
			repeat (ies) begin
				pick = $urandom_range(0, 9);
				body.delete();
				if (pick < 2) begin
					msg.push_back(8'($urandom_range(8'h80, 8'hFF)));
				end else if (pick < 6) begin
					// now and then fill the list up to and past its limit
					count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) :
						$urandom_range(0, 4);
					repeat (count) begin
						slice_len = ITEM_LENGTHS[$urandom_range(0, 4)];
						if ($urandom_range(0, 24) == 0)
							slice_len = 8'($urandom_range(0, 9));
						body.push_back(slice_len);
						repeat (slice_len) body.push_back(8'($urandom));
					end
					len = body.size();
					if ($urandom_range(0, 14) == 0)
						len = (len > 0 && $urandom_range(0, 1) == 1) ? len - 1 : len + 1;
					msg.push_back(pick[0] ? IEI_ALLOWED : IEI_CONFIGURED);
					msg.push_back(8'(len));
					foreach (body[k]) msg.push_back(body[k]);
				end else if (pick < 8) begin
					do
						iei = 8'($urandom_range(0, 127));
					while (iei == IEI_ALLOWED || iei == IEI_CONFIGURED ||
						(iei >= IEI_LONG_LO && iei <= IEI_LONG_HI));
					len = $urandom_range(0, 6);
					msg.push_back(iei);
					msg.push_back(8'(len));
					repeat (len) msg.push_back(8'($urandom));
				end else begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300) :
						$urandom_range(0, 8);
					msg.push_back(8'($urandom_range(IEI_LONG_LO, IEI_LONG_HI)));
					msg.push_back(8'(len >> 8));
					msg.push_back(8'(len));
					repeat (len) msg.push_back(8'($urandom));
				end
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut)
					void'(msg.pop_back());
			end else if (pick == 1) begin
				msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
			end
		end
	endtask

	// ---------------------------------------------------------------- sender

	// Offer one word at the falling edge after a random gap, hold it until taken
	task automatic send_octet(in_word_t w);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 39) == 0)
			snd_quiet = !snd_quiet;
		gap = snd_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			octet_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		octet_valid <= 1'b1;
		octet <= w;
		do
			@(posedge clk);
		while (octet_stall);
		parse_octet(w);
		octets_sent++;
	endtask

	initial begin : stimulus
		script_row_t row;
		arst_n = 1'b0;
		octet_valid = 1'b0;
		octet = '0;
		clear_parser();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the script; typed rows replace the predicted status word
		for (int i = 0; i < $size(SCRIPT); i++) begin
			row = SCRIPT[i];
			send_octet(in_word_t'({row.data, row.eom}));
			if (row.typed)
				due_words[due_words.size() - 1] =
					status_word(row.st, row.reg_nib, row.acnt, row.ccnt);
		end

		// Random messages, last octet of each flagged as end of message
		while (octets_sent < RANDOM_OCTETS) begin
			build_message();
			foreach (msg[i])
				send_octet(in_word_t'({msg[i], i == msg.size() - 1}));
		end
		@(negedge clk);
		octet_valid <= 1'b0;

		// Drain; the watchdog catches a block that never delivers
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d octets, %0d slice words, %0d status words, %0d mismatches.",
			octets_sent, slice_words, status_words, fail_count);
		$display("Status mix: ok %0d short %0d trunc %0d elem %0d item %0d many %0d len %0d",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_TRUNC_LEN],
			status_seen[ST_ELEM_OVR], status_seen[ST_ITEM_OVR],
			status_seen[ST_TOO_MANY], status_seen[ST_BAD_LEN]);
		if (fail_count == 0)
			$display("** registration_accept_ie_parser_core: PASSED **");
		else
			$display("** registration_accept_ie_parser_core: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- receiver

	// Stall for a random count before each word; once, hold off long enough
	// for the internal queue to fill and push back on the octet side.
	initial begin : receiver
		int hold;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				rcv_quiet = !rcv_quiet;
			hold = rcv_quiet ? 0 : $urandom_range(0, 6);
			if (!long_hold_done && words_taken >= HOLD_AT_WORD) begin
				hold = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!result_valid);
		end
	end

	// ---------------------------------------------------------------- checker

	task automatic check_field(string name, logic [23:0] exp_v, logic [23:0] act_v);
		if (exp_v !== act_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t ns: word %0d %s mismatch, expected %0h, actual %0h",
					$time, words_taken, name, exp_v, act_v);
		end
	endtask

	// Compare every taken word, field by field, against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (result.kind == KIND_STATUS) begin
				status_words++;
				status_seen[result.status]++;
			end else begin
				slice_words++;
			end
			if (due_words.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t ns: unexpected word, expected none, actual %0h",
						$time, result);
			end else begin
				want = due_words.pop_front();
				check_field("kind", 24'(want.kind), 24'(result.kind));
				check_field("list_kind", 24'(want.list_kind), 24'(result.list_kind));
				check_field("slice_index", 24'(want.slice_index), 24'(result.slice_index));
				check_field("sst", 24'(want.sst), 24'(result.sst));
				check_field("sd", want.sd, result.sd);
				check_field("home_sst", 24'(want.home_sst), 24'(result.home_sst));
				check_field("home_sd", want.home_sd, result.home_sd);
				check_field("present_mask", 24'(want.present_mask), 24'(result.present_mask));
				check_field("status", 24'(want.status), 24'(result.status));
				check_field("registration_octet", 24'(want.registration_octet),
					24'(result.registration_octet));
				check_field("allowed_count", 24'(want.allowed_count),
					24'(result.allowed_count));
				check_field("configured_count", 24'(want.configured_count),
					24'(result.configured_count));
			end
			words_taken++;
		end
	end

	// ---------------------------------------------------------------- watchdog

	// Count cycles with no handshake on either side; give up at the limit
	always @(posedge clk) begin
		if ((octet_valid && !octet_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t ns: no handshake for %0d cycles, %0d words still due",
				$time, WATCHDOG_LIMIT, due_words.size());
			$display("** registration_accept_ie_parser_core: FAILED **");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
